[rtl/sri_pkg.sv]
package sri_pkg;

  // Rectangle edges, in result mask bit order
  localparam int NUM_EDGES = 4;
  localparam int EDGE_LEFT = 0;
  localparam int EDGE_RIGHT = 1;
  localparam int EDGE_TOP = 2;
  localparam int EDGE_BOTTOM = 3;

  // Which way an edge runs
  typedef enum logic {
    ORIENT_HORZ,
    ORIENT_VERT
  } orient_t;

  // Stage advance enables handed from the pipeline control to each edge unit
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } sri_adv_t;

endpackage

[rtl/sri_edge.sv]
// One rectangle edge against the segment: multiply, combine, compare stages.
// The edge is axis aligned, so one of its two extents is zero and d and nA
// each need a single product.
module sri_edge import sri_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter orient_t ORIENT = ORIENT_VERT
) (
  input  logic                         clk,
  input  sri_adv_t                     adv,
  input  logic [COORD_BITS-2:0]        ext,
  input  logic signed [COORD_BITS:0]   sx,
  input  logic signed [COORD_BITS:0]   sy,
  input  logic signed [COORD_BITS+1:0] ox,
  input  logic signed [COORD_BITS+1:0] oy,
  output logic                         edge_hit
);

  localparam int OW = COORD_BITS + 2;
  localparam int PW = 2 * COORD_BITS + 3;
  localparam int W  = 2 * COORD_BITS + 4;

  logic signed [COORD_BITS-1:0] ext_s;
  logic signed [OW-1:0] d_src;
  logic signed [OW-1:0] a_src;
  logic signed [PW-1:0] pd_next, pa_next, p1_next, p2_next;
  logic signed [PW-1:0] pd, pa, p1, p2;
  logic signed [W-1:0]  d_next, na_next, nb_next;
  logic signed [W-1:0]  d, na, nb;
  logic d_zero, d_neg, na_le0, nb_le0;
  logic edge_hit_next;

  // Stage 2: products
  assign ext_s = $signed({1'b0, ext});
  assign d_src = (ORIENT == ORIENT_VERT) ? OW'(sx) : OW'(sy);
  assign a_src = (ORIENT == ORIENT_VERT) ? ox : oy;
  assign pd_next = PW'(ext_s) * PW'(d_src);
  assign pa_next = PW'(ext_s) * PW'(a_src);
  assign p1_next = PW'(sx) * PW'(oy);
  assign p2_next = PW'(sy) * PW'(ox);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pd <= pd_next;
      pa <= pa_next;
      p1 <= p1_next;
      p2 <= p2_next;
    end
  end

  // Stage 3: d = ey*sx - ex*sy, nA = ex*oy - ey*ox, nB = sx*oy - sy*ox
  assign d_next  = (ORIENT == ORIENT_VERT) ? W'(pd) : -W'(pd);
  assign na_next = (ORIENT == ORIENT_VERT) ? -W'(pa) : W'(pa);
  assign nb_next = W'(p1) - W'(p2);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      d  <= d_next;
      na <= na_next;
      nb <= nb_next;
    end
  end

  // Stage 4: both parameters within [0,1] without dividing
  assign d_zero = (d == '0);
  assign d_neg  = d[W-1];
  assign na_le0 = na[W-1] || (na == '0);
  assign nb_le0 = nb[W-1] || (nb == '0);

  always_comb begin
    edge_hit_next = 1'b0;
    if (!d_zero) begin
      if (d_neg) begin
        edge_hit_next = na_le0 && nb_le0 && (na >= d) && (nb >= d);
      end else begin
        edge_hit_next = !na[W-1] && !nb[W-1] && (na <= d) && (nb <= d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      edge_hit <= edge_hit_next;
    end
  end

endmodule

[rtl/segment_rectangle_intersect.sv]
// Segment versus axis-aligned rectangle test. Each request carries a segment
// and a rectangle given as corner plus width and height; the result flags
// which rectangle edges (left, right, top, bottom) the segment crosses,
// ends included, plus a combined hit bit. Parallel or zero-length cases count
// as no hit. The block is a four-stage pipeline (differences, products,
// numerator/denominator combine, range compare). The edge that takes a request
// loads stage 1; the result then passes through the product, combine and
// compare registers. One request is taken every cycle while the output
// side keeps taking results. Each stage holds its item under backpressure and
// empty stages fill behind a stalled output.
module segment_rectangle_intersect import sri_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] seg_start_x,
  input  logic signed [COORD_BITS-1:0] seg_start_y,
  input  logic signed [COORD_BITS-1:0] seg_end_x,
  input  logic signed [COORD_BITS-1:0] seg_end_y,
  input  logic signed [COORD_BITS-1:0] rect_x,
  input  logic signed [COORD_BITS-1:0] rect_y,
  input  logic [COORD_BITS-2:0]        rect_w,
  input  logic [COORD_BITS-2:0]        rect_h,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [NUM_EDGES-1:0]         edge_hits
);

  localparam int SW = COORD_BITS + 1;
  localparam int OW = COORD_BITS + 2;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  sri_adv_t adv;

  logic signed [SW-1:0] sx, sy;
  logic signed [OW-1:0] ox0, ox1, oy0, oy1;
  logic [COORD_BITS-2:0] rw, rh;

  // Stage ready chain: a stage takes new data when empty or draining
  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign adv = '{s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: segment direction and start point relative to each edge origin
  always_ff @(posedge clk) begin
    if (rdy1) begin
      sx  <= SW'(seg_end_x) - SW'(seg_start_x);
      sy  <= SW'(seg_end_y) - SW'(seg_start_y);
      ox0 <= OW'(seg_start_x) - OW'(rect_x);
      ox1 <= OW'(seg_start_x) - OW'(rect_x) - OW'(rect_w);
      oy0 <= OW'(seg_start_y) - OW'(rect_y);
      oy1 <= OW'(seg_start_y) - OW'(rect_y) - OW'(rect_h);
      rw  <= rect_w;
      rh  <= rect_h;
    end
  end

  // Stages 2-4: one unit per edge
  sri_edge #(.COORD_BITS(COORD_BITS), .ORIENT(ORIENT_VERT)) u_left (
    .clk(clk), .adv(adv), .ext(rh), .sx(sx), .sy(sy), .ox(ox0), .oy(oy0),
    .edge_hit(edge_hits[EDGE_LEFT])
  );

  sri_edge #(.COORD_BITS(COORD_BITS), .ORIENT(ORIENT_VERT)) u_right (
    .clk(clk), .adv(adv), .ext(rh), .sx(sx), .sy(sy), .ox(ox1), .oy(oy0),
    .edge_hit(edge_hits[EDGE_RIGHT])
  );

  sri_edge #(.COORD_BITS(COORD_BITS), .ORIENT(ORIENT_HORZ)) u_top (
    .clk(clk), .adv(adv), .ext(rw), .sx(sx), .sy(sy), .ox(ox0), .oy(oy0),
    .edge_hit(edge_hits[EDGE_TOP])
  );

  sri_edge #(.COORD_BITS(COORD_BITS), .ORIENT(ORIENT_HORZ)) u_bottom (
    .clk(clk), .adv(adv), .ext(rw), .sx(sx), .sy(sy), .ox(ox0), .oy(oy1),
    .edge_hit(edge_hits[EDGE_BOTTOM])
  );

  assign out_valid = v4;
  assign hit = |edge_hits;

`ifndef SYNTHESIS
  // A free output slot never blocks the input side
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while output can drain");

  // An accepted request lands in stage 1
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted request lost at stage 1");

  // A request moving out of stage 3 arrives at the output
  a_s3_to_out: assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4) |=> out_valid)
    else $error("request lost between stage 3 and output");
`endif

endmodule
